>>> rtl/core/text_blank_packing_encoder_defines.svh
// Assertion macros shared by the blank packing encoder checkers.
`ifndef TEXT_BLANK_PACKING_ENCODER_DEFINES_SVH
`define TEXT_BLANK_PACKING_ENCODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TBPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbpe: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TBPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbpe: next-cycle check failed");

// Next-cycle implication that is checked through reset as well.
`define TBPE_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tbpe: reset check failed");

`endif

>>> rtl/core/tbpe_pkg.sv
// Types and constants of the text blank packing encoder.
package tbpe_pkg;

    // Result status codes
    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_BINARY_MODE = 2'd0;
    localparam logic [1:0] REG_MAX_LINE    = 2'd1;
    localparam logic [1:0] REG_MAX_OUT     = 2'd2;

    // Register reset values
    localparam logic [14:0] MAX_LINE_RESET = 15'd56;
    localparam logic [19:0] MAX_OUT_RESET  = 20'd651264;

    // Hard ceiling on the line limit
    localparam logic [14:0] LINE_LIMIT_MAX = 15'd32767;

    // Character codes
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_BLANK = 7'h20;
    localparam logic [7:0] BLANK_BYTE = 8'h20;
    localparam logic [7:0] RUN_OFFSET = 8'h80;

    localparam logic [14:0] BLANK_SAT = 15'h7FFF;
    localparam logic [19:0] BYTES_SAT = 20'hFFFFF;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       is_last;
    } res_t;

    // All results caused by one input byte
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } bundle_t;

endpackage

>>> rtl/core/tbpe_front.sv
// Front end: configuration, line state and classification of each input byte.
module tbpe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [19:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    input  logic              q_full,
    output logic              q_push,
    output tbpe_pkg::bundle_t q_data
);
    import tbpe_pkg::*;

    logic        binary_mode_reg;
    logic [14:0] max_line_reg;
    logic [19:0] max_out_reg;

    logic [14:0] blank_run_reg, blank_run_next;
    logic [15:0] column_pos_reg, column_pos_next;
    logic [19:0] bytes_out_reg, bytes_out_next;
    logic        full_flag_reg, full_flag_next;

    logic [15:0] lim;
    logic [6:0]  ch7, ch;
    logic        is_tab, is_lf, is_blank;
    logic        bo_ge, bo1_ge;
    logic [20:0] bo_inc;

    // tab expansion
    logic [15:0] col_p1, stop, tab_end;
    logic [3:0]  tab_delta;
    logic [15:0] br_sum;

    // text path
    logic [14:0] br0;
    logic [15:0] col0;
    logic        flush, full_a, full1, ge1;
    logic [19:0] bo1;
    logic [7:0]  code;
    res_t        res_flush, res_char;
    logic        char_emits;
    logic [15:0] br_p1;

    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_mode_reg <= 1'b0;
            max_line_reg    <= MAX_LINE_RESET;
            max_out_reg     <= MAX_OUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BINARY_MODE: binary_mode_reg <= cfg_data[0];
                REG_MAX_LINE:    max_line_reg    <= cfg_data[14:0];
                REG_MAX_OUT:     max_out_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared decode
    always_comb begin
        lim      = {1'b0, (max_line_reg > LINE_LIMIT_MAX) ? LINE_LIMIT_MAX : max_line_reg};
        ch7      = s_in_byte[6:0];
        is_tab   = (ch7 == CH_TAB);
        is_lf    = (ch7 == CH_LF);
        ch       = is_lf ? CH_CR : ch7;
        is_blank = (ch == CH_BLANK);
        bo_inc   = {1'b0, bytes_out_reg} + 21'd1;
        bo_ge    = (bytes_out_reg >= max_out_reg);
        bo1_ge   = (bo_inc >= {1'b0, max_out_reg});
    end

    // Tab: advance to the next stop or the line limit, whichever is first; at the limit, one column
    always_comb begin
        col_p1    = column_pos_reg + 16'd1;
        stop      = ((column_pos_reg + 16'd7) & ~16'd7) + 16'd1;
        if (col_p1 >= lim) begin
            tab_end = col_p1;
        end else begin
            tab_end = (stop < lim) ? stop : lim;
        end
        tab_delta = 4'(tab_end - column_pos_reg);
        br_sum    = {1'b0, blank_run_reg} + {12'd0, tab_delta};
    end

    // Text path: pending blank run, then the character itself
    always_comb begin
        br0   = is_lf ? 15'd0 : blank_run_reg;
        col0  = is_lf ? 16'd0 : column_pos_reg;
        flush = !is_blank && (br0 != 15'd0);
        code  = (br0 == 15'd1) ? BLANK_BYTE : (br0[7:0] ^ RUN_OFFSET);

        full_a = full_flag_reg || bo_ge;
        res_flush.out_byte = full_a ? 8'd0 : code;
        res_flush.status   = full_a ? ST_FULL : ST_WRITTEN;
        res_flush.is_last  = 1'b0;

        if (flush) begin
            full1 = full_a;
            bo1   = full_a ? bytes_out_reg : bo_inc[19:0];
            ge1   = full_a ? bo_ge : bo1_ge;
        end else begin
            full1 = full_flag_reg;
            bo1   = bytes_out_reg;
            ge1   = bo_ge;
        end

        br_p1 = {1'b0, br0} + 16'd1;
        res_char.out_byte = 8'd0;
        res_char.status   = ST_DROPPED;
        res_char.is_last  = 1'b1;
        char_emits        = 1'b1;
        if (col0 > lim) begin
            char_emits = 1'b1;
        end else if (is_blank) begin
            char_emits = 1'b0;
        end else if (full1 || ge1) begin
            res_char.status = ST_FULL;
        end else begin
            res_char.out_byte = {1'b0, ch};
            res_char.status   = ST_WRITTEN;
        end
    end

    // Next state and the bundle for the queue
    always_comb begin
        blank_run_next  = blank_run_reg;
        column_pos_next = column_pos_reg;
        bytes_out_next  = bytes_out_reg;
        full_flag_next  = full_flag_reg;
        q_push          = 1'b0;
        q_data          = '0;

        priority if (binary_mode_reg) begin
            q_push            = accept;
            q_data.r0         = '{out_byte: s_in_byte, status: ST_WRITTEN, is_last: 1'b1};
            bytes_out_next    = (bytes_out_reg != BYTES_SAT) ? bo_inc[19:0] : bytes_out_reg;
        end else if (is_tab) begin
            if (column_pos_reg > lim) begin
                q_push    = accept;
                q_data.r0 = '{out_byte: 8'd0, status: ST_DROPPED, is_last: 1'b1};
            end else begin
                column_pos_next = tab_end;
                blank_run_next  = (br_sum > {1'b0, BLANK_SAT}) ? BLANK_SAT : br_sum[14:0];
            end
        end else begin
            q_push = accept && (flush || char_emits);
            if (flush && char_emits) begin
                q_data.r0  = res_flush;
                q_data.r1  = res_char;
                q_data.two = 1'b1;
            end else if (flush) begin
                q_data.r0         = res_flush;
                q_data.r0.is_last = 1'b1;
            end else begin
                q_data.r0 = res_char;
            end

            // state after the optional flush
            blank_run_next  = flush ? 15'd0 : br0;
            column_pos_next = col0;
            bytes_out_next  = bo1;
            full_flag_next  = full1;
            if (col0 > lim) begin
                // character dropped; only the optional flush above changes state
            end else if (is_blank) begin
                blank_run_next  = (br0 < BLANK_SAT) ? br_p1[14:0] : br0;
                column_pos_next = col0 + 16'd1;
            end else begin
                column_pos_next = col0 + 16'd1;
                if (full1 || ge1) begin
                    full_flag_next = 1'b1;
                end else begin
                    bytes_out_next = bo1 + 20'd1;
                end
            end
        end
    end

    // State registers advance on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_run_reg  <= '0;
            column_pos_reg <= '0;
            bytes_out_reg  <= '0;
            full_flag_reg  <= 1'b0;
        end else if (accept) begin
            blank_run_reg  <= blank_run_next;
            column_pos_reg <= column_pos_next;
            bytes_out_reg  <= bytes_out_next;
            full_flag_reg  <= full_flag_next;
        end
    end

endmodule

>>> rtl/core/tbpe_queue.sv
// Short FIFO of result bundles between front and back.
module tbpe_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tbpe_pkg::bundle_t push_data,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output tbpe_pkg::bundle_t head
);
    import tbpe_pkg::*;

    bundle_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (QPTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/core/tbpe_back.sv
// Back end: sends the one or two results of each bundle, one per cycle while m_ready is high.
module tbpe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  tbpe_pkg::bundle_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic [1:0]        m_status,
    output logic              m_is_last
);
    import tbpe_pkg::*;

    logic sub_reg, sub_next;
    res_t cur;
    logic xfer;

    assign m_valid    = !q_empty;
    assign cur        = sub_reg ? q_head.r1 : q_head.r0;
    assign m_out_byte = cur.out_byte;
    assign m_status   = cur.status;
    assign m_is_last  = cur.is_last;

    // Step through the bundle; pop after its last result
    always_comb begin
        xfer     = m_valid && m_ready;
        q_pop    = xfer && (!q_head.two || sub_reg);
        sub_next = sub_reg;
        if (xfer) begin
            sub_next = !q_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 1'b0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule

>>> rtl/core/text_blank_packing_encoder.sv
// Top level of the text blank packing encoder.
// Packs a byte stream for a disk image: binary mode passes bytes through, text mode
// strips bit 7, expands tabs, turns line feeds into carriage returns, folds blank runs
// into one code byte and flags over-long lines and a full disk. An input byte is
// accepted in any cycle in which the four-entry result queue has room; each byte yields
// zero, one or two results, and they leave one per cycle while m_ready is high. A result
// passes through the result queue before it is visible on the result port. The user
// must write configuration only while idle; the block itself does not enforce it.
module text_blank_packing_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_status,
    output logic        m_is_last
);
    import tbpe_pkg::*;

    logic    q_full, q_empty, q_push, q_pop;
    bundle_t q_data, q_head;

    tbpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    tbpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .empty     (q_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    tbpe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_is_last  (m_is_last)
    );

endmodule

>>> rtl/core/tbpe_checker.sv
// Port-level checker for the text blank packing encoder, bound to the top level.
`include "text_blank_packing_encoder_defines.svh"

module tbpe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic [1:0]  m_status,
    input logic        m_is_last
);
    import tbpe_pkg::*;

    // Status is one of the three defined codes
    `TBPE_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status != 2'd3)

    // A report carries a zero byte
    `TBPE_ASSERT_IMP(a_report_zero, aclk, aresetn, m_valid && (m_status != ST_WRITTEN),
                     m_out_byte == 8'd0)

    // Reset leaves no result pending
    `TBPE_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // A stalled result holds
    `TBPE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_out_byte) && $stable(m_status) && $stable(m_is_last))

    // Input is held off only while results are waiting
    `TBPE_ASSERT_NXT(a_stall_has_result, aclk, aresetn, s_valid && !s_ready, m_valid)

endmodule

bind text_blank_packing_encoder tbpe_checker u_tbpe_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_status   (m_status),
    .m_is_last  (m_is_last)
);
